FILE: design/ddst_pkg.sv
package ddst_pkg;

    // field widths
    localparam int ACT_W     = 2;
    localparam int DS_W      = 35;
    localparam int VAL_W     = 33;
    localparam int ST_W      = 3;
    localparam int FSEC_W    = 33;
    localparam int BLK_W     = 17;
    localparam int ENT_W     = 32;
    localparam int BADDR_W   = 41;
    localparam int MASK_W    = 8;
    localparam int BS_W      = 17;
    localparam int BM_W      = 5;
    localparam int DISK_W    = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 36;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 168;

    localparam int TABLE_DEPTH_DEF = 131072;

    localparam logic [ENT_W-1:0]  NO_BLOCK = 32'hFFFF_FFFF;
    localparam logic [MASK_W-1:0] TOP_BIT  = 8'h80;

    // register reset values
    localparam logic [BS_W-1:0]   BLOCK_SECTORS_RST  = 17'd4096;
    localparam logic [BM_W-1:0]   BITMAP_SECTORS_RST = 5'd1;
    localparam logic [DISK_W-1:0] DISK_SECTORS_RST   = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECTORS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_SECTORS   = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_LOAD      = 2'd2,
        ACT_SET_FREE  = 2'd3
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_MAPPED     = 3'd0,
        ST_UNALLOC    = 3'd1,
        ST_ALLOCATED  = 3'd2,
        ST_RANGE      = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_REJECTED   = 3'd5
    } status_t;

    // divider request and response
    typedef struct packed {
        logic            start;
        logic [DS_W-1:0] dividend;
        logic [BS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DS_W-1:0] quotient;
        logic [BS_W-1:0] remainder;
    } div_resp_t;

endpackage

FILE: design/ddst_ram.sv
module ddst_ram #(
    parameter int WIDTH = ddst_pkg::ENT_W,
    parameter int DEPTH = ddst_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, read-first, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ddst_divider.sv
module ddst_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  ddst_pkg::div_req_t  req,
    output ddst_pkg::div_resp_t resp
);

    import ddst_pkg::*;

    localparam int CNT_W = $clog2(DS_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DS_W-1:0]  quo_reg, quo_next;
    logic [BS_W-1:0]  rem_reg, rem_next;
    logic [BS_W-1:0]  div_reg, div_next;
    logic [BS_W:0]    trial;
    logic [BS_W:0]    diff;
    logic             fits;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, quo_reg[DS_W-1]};
        fits  = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DS_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[BS_W-1:0] : trial[BS_W-1:0];
            quo_next = {quo_reg[DS_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // quotient and remainder hold until the next start
    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

FILE: design/dynamic_disk_sector_translator.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser action; s_tdata disk_sector, value
// m_        out  m_tvalid/m_tready  m_tuser status; m_tdata result fields
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// Read/write requests pass through the radix-2 sector divider, then
// range check, table read and update before the result is emitted.
// Table loads and free pointer sets skip the divider and update directly.
// Reset clears control, registers and free pointer; the table RAM is not
// cleared and entries are undefined until loaded or allocated.
// With m_tready low the result holds; the next request is still accepted
// and waits in the result stage until the output register frees.
module dynamic_disk_sector_translator #(
    parameter int TABLE_DEPTH = ddst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ddst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddst_pkg::CFG_W-1:0]        cfg_wdata,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [34:0] disk_sector, [67:35] value, [71:68] zero
    input  logic [ddst_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [ddst_pkg::ACT_W-1:0]        s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [32:0] file_sector, [49:33] block_number, [81:50] entry_value,
    // [122:82] bitmap_byte_address, [130:123] bitmap_mask,
    // [163:131] free_sector, [167:164] zero
    output logic [ddst_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] status
    output logic [ddst_pkg::ST_W-1:0]         m_tuser
);

    import ddst_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [DS_W-1:0] DEPTH_LIM = DS_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_RDA,
        S_USE,
        S_LOAD,
        S_SETP,
        S_EMIT
    } fsm_t;

    fsm_t                 state_reg, state_next;
    action_t              act_reg, act_next;
    logic [DS_W-1:0]      ds_reg, ds_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [VAL_W-1:0]     fp_reg, fp_next;
    logic [BS_W-1:0]      block_sectors_reg, block_sectors_next;
    logic [BM_W-1:0]      bitmap_sectors_reg, bitmap_sectors_next;
    logic [DISK_W-1:0]    disk_sectors_reg, disk_sectors_next;

    status_t              res_status_reg, res_status_next;
    logic [FSEC_W-1:0]    res_fsec_reg, res_fsec_next;
    logic [BLK_W-1:0]     res_blk_reg, res_blk_next;
    logic [ENT_W-1:0]     res_ent_reg, res_ent_next;
    logic [BADDR_W-1:0]   res_baddr_reg, res_baddr_next;
    logic [MASK_W-1:0]    res_mask_reg, res_mask_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [ST_W-1:0]      m_tuser_reg, m_tuser_next;

    logic [BS_W-1:0]      bs_eff;
    logic                 s_accept;
    div_req_t             div_req;
    div_resp_t            div_resp;
    logic                 ram_we;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [BS_W-1:0]      in_blk;
    logic [DS_W+1:0]      load_sum;
    logic [FSEC_W-1:0]    fsec_map;
    logic [FSEC_W-1:0]    fsec_alloc;
    logic [VAL_W-1:0]     fp_adv;
    logic [BADDR_W-1:0]   baddr_map;

    // zero block size acts as one
    assign bs_eff   = (block_sectors_reg == '0) ? BS_W'(1) : block_sectors_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // sector divider: disk sector / block size
    assign div_req.start    = s_accept && (s_tuser == ACT_READ || s_tuser == ACT_WRITE);
    assign div_req.dividend = s_tdata[DS_W-1:0];
    assign div_req.divisor  = bs_eff;

    ddst_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    // block table; requests run one at a time, so a write back always
    // lands before the next read of the table
    ddst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // datapath terms
    assign in_blk     = div_resp.remainder;
    assign load_sum   = (DS_W+2)'(val_reg) + (DS_W+2)'(bitmap_sectors_reg)
                      + (DS_W+2)'(bs_eff);
    assign fsec_map   = FSEC_W'(ram_rdata) + FSEC_W'(bitmap_sectors_reg)
                      + FSEC_W'(in_blk);
    assign fsec_alloc = fp_reg + FSEC_W'(bitmap_sectors_reg) + FSEC_W'(in_blk);
    assign fp_adv     = fp_reg + VAL_W'(bitmap_sectors_reg) + VAL_W'(bs_eff);
    assign baddr_map  = {ram_rdata, 9'd0} + BADDR_W'(in_blk[BS_W-1:3]);

    // table write strobe
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = val_reg[ENT_W-1:0];
        if (state_reg == S_LOAD) begin
            ram_we = (ds_reg < DEPTH_LIM) && !((val_reg != VAL_W'(NO_BLOCK)) &&
                     (val_reg[VAL_W-1] || (load_sum > (DS_W+2)'(fp_reg))));
        end else if (state_reg == S_USE) begin
            ram_wdata = fp_reg[ENT_W-1:0];
            ram_we    = (ram_rdata == NO_BLOCK) && (act_reg == ACT_WRITE) &&
                        (fp_reg < VAL_W'(NO_BLOCK));
        end
    end

    // sequencer
    always_comb begin
        state_next          = state_reg;
        act_next            = act_reg;
        ds_next             = ds_reg;
        val_next            = val_reg;
        addr_next           = addr_reg;
        fp_next             = fp_reg;
        block_sectors_next  = block_sectors_reg;
        bitmap_sectors_next = bitmap_sectors_reg;
        disk_sectors_next   = disk_sectors_reg;
        res_status_next     = res_status_reg;
        res_fsec_next       = res_fsec_reg;
        res_blk_next        = res_blk_reg;
        res_ent_next        = res_ent_reg;
        res_baddr_next      = res_baddr_reg;
        res_mask_next       = res_mask_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLOCK_SECTORS:  block_sectors_next  = cfg_wdata[BS_W-1:0];
                REG_BITMAP_SECTORS: bitmap_sectors_next = cfg_wdata[BM_W-1:0];
                REG_DISK_SECTORS:   disk_sectors_next   = cfg_wdata[DISK_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    act_next  = action_t'(s_tuser);
                    ds_next   = s_tdata[DS_W-1:0];
                    val_next  = s_tdata[DS_W+VAL_W-1:DS_W];
                    addr_next = s_tdata[IDX_W-1:0];
                    res_status_next = ST_MAPPED;
                    res_fsec_next   = '0;
                    res_blk_next    = '0;
                    res_ent_next    = '0;
                    res_baddr_next  = '0;
                    res_mask_next   = '0;
                    unique case (action_t'(s_tuser))
                        ACT_LOAD:     state_next = S_LOAD;
                        ACT_SET_FREE: state_next = S_SETP;
                        default:      state_next = S_DIV;
                    endcase
                end
            end
            S_DIV: begin
                if (div_resp.done) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                // range check, then address the table
                if (({1'b0, ds_reg} >= disk_sectors_reg) ||
                    (div_resp.quotient >= DEPTH_LIM)) begin
                    res_status_next = ST_RANGE;
                    state_next      = S_EMIT;
                end else begin
                    res_blk_next = BLK_W'(div_resp.quotient);
                    addr_next    = div_resp.quotient[IDX_W-1:0];
                    state_next   = S_RDA;
                end
            end
            S_RDA: begin
                state_next = S_USE;
            end
            S_USE: begin
                if (ram_rdata == NO_BLOCK) begin
                    if (act_reg == ACT_READ) begin
                        res_status_next = ST_UNALLOC;
                    end else if (fp_reg >= VAL_W'(NO_BLOCK)) begin
                        res_status_next = ST_OVERFLOW;
                    end else begin
                        res_status_next = ST_ALLOCATED;
                        res_ent_next    = fp_reg[ENT_W-1:0];
                        res_fsec_next   = fsec_alloc;
                        fp_next         = fp_adv;
                    end
                end else begin
                    res_status_next = ST_MAPPED;
                    res_fsec_next   = fsec_map;
                    if (act_reg == ACT_WRITE) begin
                        res_baddr_next = baddr_map;
                        res_mask_next  = TOP_BIT >> in_blk[2:0];
                    end
                end
                state_next = S_EMIT;
            end
            S_LOAD: begin
                if (ds_reg >= DEPTH_LIM) begin
                    res_status_next = ST_RANGE;
                end else begin
                    res_blk_next = BLK_W'(ds_reg);
                    if (val_reg == VAL_W'(NO_BLOCK)) begin
                        res_status_next = ST_UNALLOC;
                    end else if (val_reg[VAL_W-1] ||
                                 (load_sum > (DS_W+2)'(fp_reg))) begin
                        res_status_next = ST_REJECTED;
                    end else begin
                        res_status_next = ST_MAPPED;
                    end
                end
                state_next = S_EMIT;
            end
            S_SETP: begin
                fp_next    = val_reg;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hand over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {4'd0, fp_reg, res_mask_reg, res_baddr_reg,
                                     res_ent_reg, res_blk_reg, res_fsec_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            m_tvalid_reg       <= 1'b0;
            fp_reg             <= '0;
            block_sectors_reg  <= BLOCK_SECTORS_RST;
            bitmap_sectors_reg <= BITMAP_SECTORS_RST;
            disk_sectors_reg   <= DISK_SECTORS_RST;
        end else begin
            state_reg          <= state_next;
            m_tvalid_reg       <= m_tvalid_next;
            fp_reg             <= fp_next;
            block_sectors_reg  <= block_sectors_next;
            bitmap_sectors_reg <= bitmap_sectors_next;
            disk_sectors_reg   <= disk_sectors_next;
        end
        act_reg        <= act_next;
        ds_reg         <= ds_next;
        val_reg        <= val_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_fsec_reg   <= res_fsec_next;
        res_blk_reg    <= res_blk_next;
        res_ent_reg    <= res_ent_next;
        res_baddr_reg  <= res_baddr_next;
        res_mask_reg   <= res_mask_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // table is written only while an item is applied to it
    a_ram_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_LOAD || state_reg == S_USE))
        else $error("table write outside load or update");

    // divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_resp.done |-> (state_reg == S_DIV))
        else $error("divider done while sequencer not waiting");

    // bitmap mask appears only on mapped results
    a_mask_mapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[130:123] != '0) |-> (m_tuser == ST_MAPPED))
        else $error("bitmap mask on a result that is not mapped");

    // a fresh allocation hands out the pointer it advanced from
    a_alloc_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_USE && state_next == S_EMIT &&
         res_status_next == ST_ALLOCATED) |=> (res_ent_reg == $past(fp_reg[ENT_W-1:0])))
        else $error("allocated entry differs from free pointer");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
